// File: design/cst_pkg.sv
// Shared types and constants of the C subset tokenizer.
// No dependencies; used by the channel interfaces and the top level.
package cst_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned KindW  = 5;
  localparam int unsigned ValueW = 64;
  localparam int unsigned StartW = 12;
  localparam int unsigned LenW   = 13;

  localparam int unsigned MaxSource = 4096;

  typedef enum logic [KindW-1:0] {
    K_INT    = 5'd0,
    K_IDENT  = 5'd1,
    K_PLUS   = 5'd2,
    K_MINUS  = 5'd3,
    K_STAR   = 5'd4,
    K_SLASH  = 5'd5,
    K_AMP    = 5'd6,
    K_LT     = 5'd7,
    K_LE     = 5'd8,
    K_GT     = 5'd9,
    K_GE     = 5'd10,
    K_ASSIGN = 5'd11,
    K_EQ     = 5'd12,
    K_NE     = 5'd13,
    K_LPAREN = 5'd14,
    K_RPAREN = 5'd15,
    K_LBRACE = 5'd16,
    K_RBRACE = 5'd17,
    K_LBRACK = 5'd18,
    K_RBRACK = 5'd19,
    K_SEMI   = 5'd20,
    K_COMMA  = 5'd21,
    K_EOF    = 5'd22,
    K_ERR    = 5'd23
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [ValueW-1:0]  value;
    logic [StartW-1:0]  start_pos;
    logic [LenW-1:0]    token_len;
    logic               last;
  } tok_t;

endpackage

// File: design/cst_if.sv
// Request channels of the C subset tokenizer: source bytes in, tokens out.
// Depends on cst_pkg for field widths.
interface cst_char_if;
  logic                       valid;
  logic                       ready;
  logic [cst_pkg::CharW-1:0]  char_in;

  modport source (output valid, output char_in, input ready);
  modport sink   (input valid, input char_in, output ready);
endinterface

interface cst_tok_if;
  logic                        valid;
  logic                        ready;
  logic [cst_pkg::KindW-1:0]   kind;
  logic [cst_pkg::ValueW-1:0]  value;
  logic [cst_pkg::StartW-1:0]  start_pos;
  logic [cst_pkg::LenW-1:0]    token_len;
  logic                        last;

  modport source (output valid, output kind, output value, output start_pos,
                  output token_len, output last, input ready);
  modport sink   (input valid, input kind, input value, input start_pos,
                  input token_len, input last, output ready);
endinterface

// File: design/c_subset_tokenizer.sv
// Streaming tokenizer for a small C subset: one source byte per request in,
// zero, one or two token requests out. One byte is accepted every cycle while
// the four-entry token queue has room for two tokens; a token is queued with
// the byte that completes it. Throughput is set by the single queue read
// port: one token per cycle while the sink is ready. Reset clears the scanner
// and the queue. Depends on cst_pkg and the channel interfaces in cst_if.sv.
module c_subset_tokenizer #(
  parameter int unsigned MAX_SOURCE = cst_pkg::MaxSource
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  cst_char_if.sink      char_i,
  cst_tok_if.source     tok_o
);

  localparam int unsigned PosW   = $clog2(MAX_SOURCE);
  localparam int unsigned QDepth = 4;
  localparam int unsigned QIdxW  = $clog2(QDepth);

  typedef enum logic [2:0] {
    M_IDLE, M_INT, M_IDENT, M_LT, M_GT, M_EQ, M_BANG, M_HALT
  } mode_e;

  mode_e                        mode_q, mode_d;
  logic [cst_pkg::ValueW-1:0]   acc_q, acc_d;
  logic [PosW-1:0]              pos_q, pos_d;
  logic [PosW-1:0]              ts_q, ts_d;

  cst_pkg::tok_t                q_q [QDepth];
  cst_pkg::tok_t                q_d [QDepth];
  logic [QIdxW:0]               cnt_q, cnt_d, cnt_pop;

  logic                         in_fire, pop;
  logic                         p_v, f_v;
  cst_pkg::tok_t                p_t, f_t, res0, res1;
  logic [1:0]                   nres;
  logic [PosW:0]                diff, diff1;
  logic [7:0]                   c;
  logic                         again;

  function automatic logic [cst_pkg::LenW-1:0] to_len(input logic [PosW:0] x);
    logic [PosW+cst_pkg::LenW:0] e;
    e = {{cst_pkg::LenW{1'b0}}, x};
    return e[cst_pkg::LenW-1:0];
  endfunction

  function automatic logic [cst_pkg::StartW-1:0] to_start(input logic [PosW-1:0] x);
    logic [PosW+cst_pkg::StartW-1:0] e;
    e = {{cst_pkg::StartW{1'b0}}, x};
    return e[cst_pkg::StartW-1:0];
  endfunction

  function automatic cst_pkg::tok_t mk(input cst_pkg::kind_e k,
                                       input logic [cst_pkg::ValueW-1:0] v,
                                       input logic [PosW-1:0] s,
                                       input logic [PosW:0] l);
    cst_pkg::tok_t t;
    t.kind      = k;
    t.value     = v;
    t.start_pos = to_start(s);
    t.token_len = to_len(l);
    t.last      = 1'b0;
    return t;
  endfunction

  function automatic logic is_digit(input logic [7:0] ch);
    return (ch >= "0") && (ch <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] ch);
    return ((ch >= "a") && (ch <= "z")) || ((ch >= "A") && (ch <= "Z"));
  endfunction

  assign c       = char_i.char_in;
  assign in_fire = char_i.valid && char_i.ready;
  assign diff    = {1'b0, pos_q} - {1'b0, ts_q};
  assign diff1   = diff + (PosW+1)'(1);

  // scanner: pending token first, then the byte as a fresh start
  always_comb begin
    mode_d = mode_q;
    acc_d  = acc_q;
    ts_d   = ts_q;
    p_v    = 1'b0;
    p_t    = '0;
    f_v    = 1'b0;
    f_t    = '0;
    again  = 1'b0;

    unique case (mode_q)
      M_IDLE: again = 1'b1;
      M_INT: begin
        if (is_digit(c)) begin
          acc_d = (acc_q << 3) + (acc_q << 1) + cst_pkg::ValueW'(c - "0");
        end else begin
          p_v    = 1'b1;
          p_t    = mk(cst_pkg::K_INT, acc_q, ts_q, diff);
          mode_d = M_IDLE;
          again  = 1'b1;
        end
      end
      M_IDENT: begin
        if (!(is_alpha(c) || is_digit(c) || c == "_")) begin
          p_v    = 1'b1;
          p_t    = mk(cst_pkg::K_IDENT, '0, ts_q, diff);
          mode_d = M_IDLE;
          again  = 1'b1;
        end
      end
      M_LT, M_GT, M_EQ: begin
        mode_d = M_IDLE;
        p_v    = 1'b1;
        if (c == "=") begin
          priority case (mode_q)
            M_LT:    p_t = mk(cst_pkg::K_LE, '0, ts_q, diff1);
            M_GT:    p_t = mk(cst_pkg::K_GE, '0, ts_q, diff1);
            default: p_t = mk(cst_pkg::K_EQ, '0, ts_q, diff1);
          endcase
        end else begin
          priority case (mode_q)
            M_LT:    p_t = mk(cst_pkg::K_LT, '0, ts_q, diff);
            M_GT:    p_t = mk(cst_pkg::K_GT, '0, ts_q, diff);
            default: p_t = mk(cst_pkg::K_ASSIGN, '0, ts_q, diff);
          endcase
          again = 1'b1;
        end
      end
      M_BANG: begin
        p_v = 1'b1;
        if (c == "=") begin
          p_t    = mk(cst_pkg::K_NE, '0, ts_q, diff1);
          mode_d = M_IDLE;
        end else begin
          p_t    = mk(cst_pkg::K_ERR, '0, ts_q, (PosW+1)'(1));
          mode_d = M_HALT;
        end
      end
      M_HALT: ;
      default: ;
    endcase

    if (again) begin
      priority if (c == 8'd0) begin
        f_v    = 1'b1;
        f_t    = mk(cst_pkg::K_EOF, '0, pos_q, '0);
        mode_d = M_HALT;
      end else if (c == " " || c == 8'h09 || c == 8'h0a || c == 8'h0d) begin
        mode_d = M_IDLE;
      end else if (is_digit(c)) begin
        mode_d = M_INT;
        acc_d  = cst_pkg::ValueW'(c - "0");
        ts_d   = pos_q;
      end else if (is_alpha(c) || c == "_") begin
        mode_d = M_IDENT;
        ts_d   = pos_q;
      end else if (c == "<") begin
        mode_d = M_LT;
        ts_d   = pos_q;
      end else if (c == ">") begin
        mode_d = M_GT;
        ts_d   = pos_q;
      end else if (c == "=") begin
        mode_d = M_EQ;
        ts_d   = pos_q;
      end else if (c == "!") begin
        mode_d = M_BANG;
        ts_d   = pos_q;
      end else begin
        f_v = 1'b1;
        unique case (c)
          "+":     f_t = mk(cst_pkg::K_PLUS,   '0, pos_q, (PosW+1)'(1));
          "-":     f_t = mk(cst_pkg::K_MINUS,  '0, pos_q, (PosW+1)'(1));
          "*":     f_t = mk(cst_pkg::K_STAR,   '0, pos_q, (PosW+1)'(1));
          "/":     f_t = mk(cst_pkg::K_SLASH,  '0, pos_q, (PosW+1)'(1));
          "&":     f_t = mk(cst_pkg::K_AMP,    '0, pos_q, (PosW+1)'(1));
          "(":     f_t = mk(cst_pkg::K_LPAREN, '0, pos_q, (PosW+1)'(1));
          ")":     f_t = mk(cst_pkg::K_RPAREN, '0, pos_q, (PosW+1)'(1));
          "{":     f_t = mk(cst_pkg::K_LBRACE, '0, pos_q, (PosW+1)'(1));
          "}":     f_t = mk(cst_pkg::K_RBRACE, '0, pos_q, (PosW+1)'(1));
          "[":     f_t = mk(cst_pkg::K_LBRACK, '0, pos_q, (PosW+1)'(1));
          "]":     f_t = mk(cst_pkg::K_RBRACK, '0, pos_q, (PosW+1)'(1));
          ";":     f_t = mk(cst_pkg::K_SEMI,   '0, pos_q, (PosW+1)'(1));
          ",":     f_t = mk(cst_pkg::K_COMMA,  '0, pos_q, (PosW+1)'(1));
          default: begin
            f_t    = mk(cst_pkg::K_ERR, '0, pos_q, (PosW+1)'(1));
            mode_d = M_HALT;
          end
        endcase
      end
    end

    pos_d = (pos_q < PosW'(MAX_SOURCE - 1)) ? pos_q + PosW'(1) : pos_q;
  end

  // order results and mark the final one
  always_comb begin
    res0 = p_v ? p_t : f_t;
    res1 = f_t;
    res0.last = !(p_v && f_v);
    res1.last = 1'b1;
    nres = {1'b0, p_v} + {1'b0, f_v};
  end

  // token queue: shift out at the head, append at the tail
  assign pop     = tok_o.valid && tok_o.ready;
  assign cnt_pop = cnt_q - (QIdxW+1)'(pop);

  always_comb begin
    for (int i = 0; i < QDepth - 1; i++) begin
      q_d[i] = pop ? q_q[i+1] : q_q[i];
    end
    q_d[QDepth-1] = q_q[QDepth-1];
    cnt_d = cnt_pop;
    if (in_fire) begin
      if (nres != 2'd0) begin
        q_d[cnt_pop[QIdxW-1:0]] = res0;
      end
      if (nres == 2'd2) begin
        q_d[cnt_pop[QIdxW-1:0] + QIdxW'(1)] = res1;
      end
      cnt_d = cnt_pop + (QIdxW+1)'(nres);
    end
  end

  assign char_i.ready    = cnt_q <= (QIdxW+1)'(QDepth - 2);
  assign tok_o.valid     = cnt_q != '0;
  assign tok_o.kind      = q_q[0].kind;
  assign tok_o.value     = q_q[0].value;
  assign tok_o.start_pos = q_q[0].start_pos;
  assign tok_o.token_len = q_q[0].token_len;
  assign tok_o.last      = q_q[0].last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      acc_q  <= '0;
      pos_q  <= '0;
      ts_q   <= '0;
      cnt_q  <= '0;
    end else begin
      if (in_fire) begin
        mode_q <= mode_d;
        acc_q  <= acc_d;
        pos_q  <= pos_d;
        ts_q   <= ts_d;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
  end

endmodule

// File: dv/c_subset_tokenizer_test.sv
// Self-checking test of c_subset_tokenizer: streams one long random C-subset
// source through the byte channel and checks every token against a lexer model.
// Depends on cst_pkg, cst_if.sv and the c_subset_tokenizer RTL.
`timescale 1ns / 1ps

module c_subset_tokenizer_test;
  import cst_pkg::*;

  localparam int SourceLen = 2000;
  localparam int HoldAfter = 200;
  localparam int HoldCycles = 400;
  localparam int TailCycles = 20;
  localparam logic [StartW-1:0] PosMax = StartW'(MaxSource - 1);

  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_INT, SCAN_IDENT, SCAN_LT, SCAN_GT, SCAN_EQ, SCAN_BANG, SCAN_HALT
  } scan_e;

  typedef struct {
    logic [CharW-1:0] ch;
    bit               drain;
  } src_byte_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  cst_char_if char_if ();
  cst_tok_if  tok_if ();

  c_subset_tokenizer i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .char_i (char_if),
    .tok_o  (tok_if)
  );

  always #5 clk_i = ~clk_i;

  src_byte_t source_q[$];
  tok_t      pending_tokens[$];
  int        mismatch_cnt = 0;

  scan_e             scan_st = SCAN_IDLE;
  logic [ValueW-1:0] num_acc = '0;
  logic [StartW-1:0] src_pos = '0;
  logic [StartW-1:0] lex_start = '0;

  string blanks = " \t\n\r";
  string ops1 = "<>=+-*/&(){}[];,";
  string ops2[4] = '{"<=", ">=", "==", "!="};
  bit    drain_pending = 1'b0;

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == " " || c == "\t" || c == "\n" || c == "\r";
  endfunction

  function automatic kind_e punct_kind(logic [7:0] c);
    case (c)
      "+": return K_PLUS;
      "-": return K_MINUS;
      "*": return K_STAR;
      "/": return K_SLASH;
      "&": return K_AMP;
      "(": return K_LPAREN;
      ")": return K_RPAREN;
      "{": return K_LBRACE;
      "}": return K_RBRACE;
      "[": return K_LBRACK;
      "]": return K_RBRACK;
      ";": return K_SEMI;
      ",": return K_COMMA;
      default: return K_ERR;
    endcase
  endfunction

  // bytes that neither halt the scanner nor need a partner byte
  function automatic bit byte_ok(logic [7:0] c);
    return is_digit(c) || is_alpha(c) || c == "_" || is_blank(c) ||
           c == "<" || c == ">" || c == "=" || punct_kind(c) != K_ERR;
  endfunction

  function automatic tok_t mk_tok(kind_e k, logic [ValueW-1:0] v, logic [StartW-1:0] s,
                                  logic [LenW-1:0] len);
    tok_t t;
    t.kind = k;
    t.value = v;
    t.start_pos = s;
    t.token_len = len;
    t.last = 1'b0;
    return t;
  endfunction

  function automatic logic [LenW-1:0] span(logic [StartW-1:0] p, logic [StartW-1:0] s,
                                           bit incl);
    return {1'b0, p} - {1'b0, s} + LenW'(incl);
  endfunction

  task automatic lex_byte(input logic [CharW-1:0] c);
    tok_t  res[$];
    tok_t  t;
    bit    rescan;
    kind_e k_one;
    kind_e k_two;
    logic [StartW-1:0] p;
    rescan = 1'b0;
    p = src_pos;
    if (scan_st == SCAN_HALT) return;
    case (scan_st)
      SCAN_IDLE: rescan = 1'b1;
      SCAN_INT: begin
        if (is_digit(c)) begin
          num_acc = num_acc * 64'd10 + 64'(c - "0");
        end else begin
          res.push_back(mk_tok(K_INT, num_acc, lex_start, span(p, lex_start, 1'b0)));
          scan_st = SCAN_IDLE;
          rescan = 1'b1;
        end
      end
      SCAN_IDENT: begin
        if (!(is_alpha(c) || is_digit(c) || c == "_")) begin
          res.push_back(mk_tok(K_IDENT, '0, lex_start, span(p, lex_start, 1'b0)));
          scan_st = SCAN_IDLE;
          rescan = 1'b1;
        end
      end
      SCAN_LT, SCAN_GT, SCAN_EQ: begin
        case (scan_st)
          SCAN_LT: begin k_one = K_LT; k_two = K_LE; end
          SCAN_GT: begin k_one = K_GT; k_two = K_GE; end
          default: begin k_one = K_ASSIGN; k_two = K_EQ; end
        endcase
        scan_st = SCAN_IDLE;
        if (c == "=") begin
          res.push_back(mk_tok(k_two, '0, lex_start, span(p, lex_start, 1'b1)));
        end else begin
          res.push_back(mk_tok(k_one, '0, lex_start, span(p, lex_start, 1'b0)));
          rescan = 1'b1;
        end
      end
      SCAN_BANG: begin
        if (c == "=") begin
          res.push_back(mk_tok(K_NE, '0, lex_start, span(p, lex_start, 1'b1)));
          scan_st = SCAN_IDLE;
        end else begin
          res.push_back(mk_tok(K_ERR, '0, lex_start, LenW'(1)));
          scan_st = SCAN_HALT;
        end
      end
      default: ;
    endcase
    if (rescan) begin
      if (c == 8'd0) begin
        res.push_back(mk_tok(K_EOF, '0, p, '0));
        scan_st = SCAN_HALT;
      end else if (is_blank(c)) begin
      end else if (is_digit(c)) begin
        scan_st = SCAN_INT;
        num_acc = 64'(c - "0");
        lex_start = p;
      end else if (is_alpha(c) || c == "_") begin
        scan_st = SCAN_IDENT;
        lex_start = p;
      end else if (c == "<" || c == ">" || c == "=" || c == "!") begin
        scan_st = (c == "<") ? SCAN_LT : (c == ">") ? SCAN_GT :
                  (c == "=") ? SCAN_EQ : SCAN_BANG;
        lex_start = p;
      end else if (punct_kind(c) != K_ERR) begin
        res.push_back(mk_tok(punct_kind(c), '0, p, LenW'(1)));
      end else begin
        res.push_back(mk_tok(K_ERR, '0, p, LenW'(1)));
        scan_st = SCAN_HALT;
      end
    end
    if (src_pos != PosMax) src_pos++;
    foreach (res[i]) begin
      t = res[i];
      t.last = (i == res.size() - 1);
      pending_tokens.push_back(t);
    end
  endtask

  task automatic draw_gap(inout int run_left, inout bit calm, output int gap);
    if (run_left == 0) begin
      run_left = $urandom_range(8, 60);
      calm = ($urandom_range(0, 2) == 0);
    end
    run_left--;
    gap = calm ? 0 : $urandom_range(0, 5);
  endtask

  // byte driver
  int src_wait = 0;
  int src_run = 0;
  bit src_calm = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_if.valid <= 1'b0;
      char_if.char_in <= '0;
      src_wait = 0;
    end else begin
      if (char_if.valid && char_if.ready) begin
        lex_byte(char_if.char_in);
        draw_gap(src_run, src_calm, src_wait);
      end
      if (!char_if.valid || char_if.ready) begin
        if (src_wait > 0) begin
          src_wait--;
          char_if.valid <= 1'b0;
        end else if (source_q.size() != 0 &&
                     !(source_q[0].drain && pending_tokens.size() != 0)) begin
          char_if.char_in <= source_q[0].ch;
          char_if.valid <= 1'b1;
          void'(source_q.pop_front());
        end else begin
          char_if.valid <= 1'b0;
        end
      end
    end
  end

  // token monitor
  function automatic int field_diff(string fld, logic [63:0] want, logic [63:0] got);
    if (want === got) return 0;
    $display("%0t: %s mismatch: expected %0d, got %0d", $time, fld, want, got);
    return 1;
  endfunction

  int   snk_wait = 0;
  int   snk_run = 0;
  bit   snk_calm = 1'b0;
  int   tok_seen = 0;
  int   hold_left = 0;
  bit   hold_done = 1'b0;
  tok_t want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_if.ready <= 1'b0;
      snk_wait = 0;
    end else begin
      if (tok_if.valid && tok_if.ready) begin
        tok_seen++;
        if (pending_tokens.size() == 0) begin
          $display("%0t: unexpected token: expected none, got kind %0d start %0d len %0d",
                   $time, tok_if.kind, tok_if.start_pos, tok_if.token_len);
          mismatch_cnt++;
        end else begin
          want = pending_tokens.pop_front();
          mismatch_cnt += field_diff("kind", 64'(want.kind), 64'(tok_if.kind));
          mismatch_cnt += field_diff("value", want.value, tok_if.value);
          mismatch_cnt += field_diff("start_pos", 64'(want.start_pos), 64'(tok_if.start_pos));
          mismatch_cnt += field_diff("token_len", 64'(want.token_len), 64'(tok_if.token_len));
          mismatch_cnt += field_diff("last", 64'(want.last), 64'(tok_if.last));
        end
        draw_gap(snk_run, snk_calm, snk_wait);
      end
      if (hold_left > 0) begin
        hold_left--;
        tok_if.ready <= 1'b0;
      end else if (!hold_done && tok_seen >= HoldAfter) begin
        // hold off long enough for the token queue to fill and stall the bytes
        hold_done = 1'b1;
        hold_left = HoldCycles;
        tok_if.ready <= 1'b0;
      end else if (snk_wait > 0) begin
        snk_wait--;
        tok_if.ready <= 1'b0;
      end else begin
        tok_if.ready <= 1'b1;
      end
    end
  end

  // source text
  task automatic push_char(input logic [7:0] c);
    src_byte_t b;
    b.ch = c;
    b.drain = drain_pending;
    drain_pending = 1'b0;
    source_q.push_back(b);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
  endtask

  task automatic add_word(input int len);
    logic [7:0] c;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, (i == 0) ? 2 : 3))
        0: c = 8'("a" + $urandom_range(0, 25));
        1: c = 8'("A" + $urandom_range(0, 25));
        2: c = "_";
        default: c = 8'("0" + $urandom_range(0, 9));
      endcase
      push_char(c);
    end
  endtask

  task automatic add_number(input int len);
    for (int i = 0; i < len; i++) push_char(8'("0" + $urandom_range(0, 9)));
  endtask

  initial begin
    logic [7:0] c;
    int next_drain;
    rst_ni = 1'b0;
    char_if.valid = 1'b0;
    char_if.char_in = '0;
    tok_if.ready = 1'b0;

    push_text("a_Z9<=b>=c==d!=e<f>g=h x<>=y 12ab+-*/&(){}[];,\t\r\n");
    push_text("18446744073709551615 18446744073709551616 0 _ ");

    next_drain = 1200;
    while (source_q.size() < SourceLen) begin
      if (source_q.size() >= next_drain) begin
        drain_pending = 1'b1;
        next_drain += 1800;
      end
      case ($urandom_range(0, 11))
        0, 1, 2: add_word(($urandom_range(0, 15) == 0) ? $urandom_range(20, 60)
                                                        : $urandom_range(1, 8));
        3, 4, 5: add_number(($urandom_range(0, 7) == 0) ? $urandom_range(15, 25)
                                                         : $urandom_range(1, 6));
        6: push_text(ops2[$urandom_range(0, 3)]);
        7, 8: push_char(ops1[$urandom_range(0, ops1.len() - 1)]);
        9: begin
          do c = 8'($urandom_range(1, 127)); while (!byte_ok(c));
          push_char(c);
        end
        default: push_char(blanks[$urandom_range(0, 3)]);
      endcase
      if ($urandom_range(0, 1) == 1) push_char(blanks[$urandom_range(0, 3)]);
    end

    case ($urandom_range(0, 3))
      0: push_char(8'd0);
      1: begin
        add_word(3);
        push_char(8'd0);
      end
      2: begin
        do c = 8'($urandom_range(1, 255)); while (byte_ok(c) || c == "!");
        push_char(c);
      end
      default: begin
        push_char("!");
        do c = 8'($urandom_range(0, 255)); while (c == "=");
        push_char(c);
      end
    endcase
    // scanner is halted now; these must produce nothing
    push_char(8'hFF);
    repeat (30) push_char(8'($urandom_range(0, 255)));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (source_q.size() != 0 || char_if.valid || pending_tokens.size() != 0)
      @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (pending_tokens.size() != 0) begin
      $display("%0t: %0d expected tokens never arrived, first kind %0d start %0d",
               $time, pending_tokens.size(), pending_tokens[0].kind,
               pending_tokens[0].start_pos);
      mismatch_cnt++;
    end
    if (mismatch_cnt == 0) begin
      $display("** c_subset_tokenizer: PASSED **");
    end else begin
      $display("** c_subset_tokenizer: FAILED **");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("%0t: timeout", $time);
    $display("** c_subset_tokenizer: FAILED **");
    $finish;
  end

endmodule

// File: c_subset_tokenizer.f
design/cst_pkg.sv
design/cst_if.sv
design/c_subset_tokenizer.sv
dv/c_subset_tokenizer_test.sv
